// ----- design/binary_run_length_encoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Binary run-length encoder assertion macros
// Shared macros for the concurrent checks on the encoder unit.
// ----------------------------------------------------------------------------
`ifndef BINARY_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH
`define BINARY_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BRLE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brle check failed");

// next-cycle implication, disabled in reset
`define BRLE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brle check failed");

`endif

// ----- design/brle_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary run-length encoder package
// Widths, register indexes and the command types shared by the encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

   localparam int ImageDimDef = 4096;
   localparam int COORD_W     = 12;
   localparam int BOX_W       = 13;
   localparam int VALUE_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int QueueDepth  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_TOP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_RIGHT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_BOTTOM = 3'd3;

   localparam logic [BOX_W-1:0] BOX_RIGHT_RST  = 13'd4096;
   localparam logic [BOX_W-1:0] BOX_BOTTOM_RST = 13'd4096;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] first;
      logic [COORD_W-1:0] last;
      logic               valid;
      logic               done;
   } run_rec_type;

   typedef struct packed {
      run_rec_type head;
      run_rec_type tail;
      logic        pair;
   } run_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- design/brle_front.sv -----
// ----------------------------------------------------------------------------
// Binary run-length encoder front end
// Holds the scan box and the open run, classifies each pixel and queues the
// one or two run results that it causes as a single command.
// ----------------------------------------------------------------------------
module brle_front
   import brle_pkg::*;
#(
   parameter int IMAGE_DIM = ImageDimDef
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BOX_W-1:0]       csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_W-1:0]     req_pixel_value,
   input  logic [COORD_W-1:0]     req_pixel_row,
   input  logic [COORD_W-1:0]     req_pixel_column,
   input  logic                   req_frame_end,
   input  queue_status_type       q_status,
   output logic                   push,
   output run_cmd_type            push_cmd
);

   logic [BOX_W-1:0]   box_left_ff, box_top_ff, box_right_ff, box_bottom_ff;
   logic               run_open_ff, run_open_in;
   logic [COORD_W-1:0] open_row_ff, open_row_in;
   logic [COORD_W-1:0] open_first_ff, open_first_in;
   logic [COORD_W-1:0] open_last_ff, open_last_in;

   logic               accept;
   logic               in_image;
   logic               in_box;
   logic               foreground;
   logic               extend;
   logic               close;
   logic [BOX_W-1:0]   row_ext, col_ext;
   logic               open_after;
   run_rec_type        close_rec, flush_rec;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   assign row_ext  = {1'b0, req_pixel_row};
   assign col_ext  = {1'b0, req_pixel_column};
   assign in_image = (32'(req_pixel_row) < IMAGE_DIM) && (32'(req_pixel_column) < IMAGE_DIM);
   assign in_box   = in_image && (col_ext >= box_left_ff) && (col_ext < box_right_ff) &&
                     (row_ext >= box_top_ff) && (row_ext < box_bottom_ff);
   assign foreground = (req_pixel_value != '0);
   assign extend   = run_open_ff && (req_pixel_row == open_row_ff) &&
                     (col_ext == ({1'b0, open_last_ff} + 13'd1));
   assign close    = in_box && run_open_ff && (!foreground || !extend);

   always_comb begin
      open_after    = run_open_ff;
      open_row_in   = open_row_ff;
      open_first_in = open_first_ff;
      open_last_in  = open_last_ff;
      if (in_box && foreground) begin
         if (extend) begin
            open_last_in = req_pixel_column;
         end else begin
            open_after    = 1'b1;
            open_row_in   = req_pixel_row;
            open_first_in = req_pixel_column;
            open_last_in  = req_pixel_column;
         end
      end else if (in_box) begin
         open_after = 1'b0;
      end
      run_open_in = open_after && !req_frame_end;
   end

   always_comb begin
      close_rec.row   = open_row_ff;
      close_rec.first = open_first_ff;
      close_rec.last  = open_last_ff;
      close_rec.valid = 1'b1;
      close_rec.done  = 1'b0;
      if (open_after) begin
         flush_rec.row   = open_row_in;
         flush_rec.first = open_first_in;
         flush_rec.last  = open_last_in;
         flush_rec.valid = 1'b1;
      end else begin
         flush_rec.row   = '0;
         flush_rec.first = '0;
         flush_rec.last  = '0;
         flush_rec.valid = 1'b0;
      end
      flush_rec.done = 1'b1;
      push_cmd.head  = close ? close_rec : flush_rec;
      push_cmd.tail  = flush_rec;
      push_cmd.pair  = close && req_frame_end;
   end

   assign push = accept && (close || req_frame_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff   <= '0;
         box_top_ff    <= '0;
         box_right_ff  <= BOX_RIGHT_RST;
         box_bottom_ff <= BOX_BOTTOM_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BOX_LEFT:   box_left_ff   <= csr_data;
            CSR_BOX_TOP:    box_top_ff    <= csr_data;
            CSR_BOX_RIGHT:  box_right_ff  <= csr_data;
            CSR_BOX_BOTTOM: box_bottom_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff   <= 1'b0;
         open_row_ff   <= '0;
         open_first_ff <= '0;
         open_last_ff  <= '0;
      end else if (accept) begin
         run_open_ff   <= run_open_in;
         open_row_ff   <= open_row_in;
         open_first_ff <= open_first_in;
         open_last_ff  <= open_last_in;
      end
   end

endmodule

// ----- design/brle_queue.sv -----
// ----------------------------------------------------------------------------
// Binary run-length encoder command queue
// Short first-in first-out store of run commands between front and back.
// ----------------------------------------------------------------------------
module brle_queue
   import brle_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  run_cmd_type      push_cmd,
   input  logic             pop,
   output run_cmd_type      head_cmd,
   output queue_status_type status
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   run_cmd_type     store_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign status.full  = (count_ff == CntFull);
   assign status.empty = (count_ff == '0);
   assign head_cmd     = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrMax) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrMax) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- design/brle_back.sv -----
// ----------------------------------------------------------------------------
// Binary run-length encoder back end
// Drains queued commands into the output register, one result per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module brle_back
   import brle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  run_cmd_type        head_cmd,
   input  queue_status_type   q_status,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COORD_W-1:0] rsp_run_row,
   output logic [COORD_W-1:0] rsp_run_begin,
   output logic [COORD_W-1:0] rsp_run_end,
   output logic               rsp_run_valid,
   output logic               rsp_frame_done,
   output logic               rsp_item_last
);

   logic        rsp_valid_ff;
   logic        phase_ff;
   run_rec_type rec_ff, rec_in;
   logic        last_ff, last_in;
   logic        load;
   logic        take;

   assign load    = !rsp_valid_ff || rsp_ready;
   assign take    = load && !q_status.empty;
   assign rec_in  = phase_ff ? head_cmd.tail : head_cmd.head;
   assign last_in = !head_cmd.pair || phase_ff;
   assign pop     = take && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= !q_status.empty;
         if (take) begin
            phase_ff <= !last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rec_ff  <= rec_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_row    = rec_ff.row;
   assign rsp_run_begin  = rec_ff.first;
   assign rsp_run_end    = rec_ff.last;
   assign rsp_run_valid  = rec_ff.valid;
   assign rsp_frame_done = rec_ff.done;
   assign rsp_item_last  = last_ff;

endmodule

// ----- design/binary_run_length_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// Binary run-length encoder unit
// Turns a raster pixel stream into foreground runs of row, begin and end.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel (valid/ready), one per clock while the queue has room.
// Runs leave on the rsp_ channel (valid/ready) from an output register.
// Each result passes through the command queue and then the output register.
// Throughput: one pixel per cycle while the queue has room; one result per cycle while rsp_ready is high.
// A pixel that both closes a run and ends the frame gives two results, one
// after the other; the four-entry command queue between the classifying
// front end and the draining back end absorbs such bursts.
// When the receiver stalls, the output register holds and the queue fills;
// req_ready drops only once the queue is full.
// The csr_ port writes the scan box registers; write only while idle.
// Synchronous reset empties the queue, drops any open run and restores the
// scan box to the whole image. No clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_run_length_encoder_unit
   import brle_pkg::*;
#(
   parameter int IMAGE_DIM = ImageDimDef
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BOX_W-1:0]       csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_W-1:0]     req_pixel_value,
   input  logic [COORD_W-1:0]     req_pixel_row,
   input  logic [COORD_W-1:0]     req_pixel_column,
   input  logic                   req_frame_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COORD_W-1:0]     rsp_run_row,
   output logic [COORD_W-1:0]     rsp_run_begin,
   output logic [COORD_W-1:0]     rsp_run_end,
   output logic                   rsp_run_valid,
   output logic                   rsp_frame_done,
   output logic                   rsp_item_last
);

   queue_status_type q_status;
   run_cmd_type      push_cmd, head_cmd;
   logic             push, pop;

   brle_front #(
      .IMAGE_DIM (IMAGE_DIM)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_column (req_pixel_column),
      .req_frame_end    (req_frame_end),
      .q_status         (q_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   brle_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   brle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_run_row    (rsp_run_row),
      .rsp_run_begin  (rsp_run_begin),
      .rsp_run_end    (rsp_run_end),
      .rsp_run_valid  (rsp_run_valid),
      .rsp_frame_done (rsp_frame_done),
      .rsp_item_last  (rsp_item_last)
   );

endmodule

// ----- design/brle_checker.sv -----
// ----------------------------------------------------------------------------
// Binary run-length encoder port checker
// Concurrent checks on the result channel of the encoder unit.
// ----------------------------------------------------------------------------
`include "binary_run_length_encoder_unit_defines.svh"

module brle_checker
   import brle_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COORD_W-1:0] rsp_run_row,
   input logic [COORD_W-1:0] rsp_run_begin,
   input logic [COORD_W-1:0] rsp_run_end,
   input logic               rsp_run_valid,
   input logic               rsp_frame_done,
   input logic               rsp_item_last
);

   `BRLE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_run_row, rsp_run_begin, rsp_run_end, rsp_run_valid, rsp_frame_done, rsp_item_last}))
   `BRLE_ASSERT_IMP(a_marker_form, clock, reset, rsp_valid && !rsp_run_valid, rsp_frame_done && rsp_run_row == '0 && rsp_run_begin == '0 && rsp_run_end == '0)
   `BRLE_ASSERT_IMP(a_done_last, clock, reset, rsp_valid && rsp_frame_done, rsp_item_last)
   `BRLE_ASSERT_IMP(a_run_order, clock, reset, rsp_valid && rsp_run_valid, rsp_run_begin <= rsp_run_end)

endmodule

bind binary_run_length_encoder_unit brle_checker u_checker (.*);

// ----- bench/tb_binary_run_length_encoder_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binary run-length encoder unit testbench
// Drives raster pixel frames through the encoder under several scan boxes.
// Every accepted pixel is encoded again in the bench, and the runs it closes
// and the frame-end markers it causes are queued. Each response is then
// checked field by field against the oldest queued run, with random gaps on
// the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_binary_run_length_encoder_unit;
   import brle_pkg::*;

   localparam int WATCHDOG_LIMIT = 400;
   localparam int PIXEL_TARGET   = 1450;
   localparam int FULL_RATE_SHARE = 250;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] first;
      logic [COORD_W-1:0] last;
      logic               valid;
      logic               done;
      logic               item_last;
   } run_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BOX_W-1:0]       csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [VALUE_W-1:0]     req_pixel_value = '0;
   logic [COORD_W-1:0]     req_pixel_row = '0;
   logic [COORD_W-1:0]     req_pixel_column = '0;
   logic                   req_frame_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [COORD_W-1:0]     rsp_run_row;
   logic [COORD_W-1:0]     rsp_run_begin;
   logic [COORD_W-1:0]     rsp_run_end;
   logic                   rsp_run_valid;
   logic                   rsp_frame_done;
   logic                   rsp_item_last;

   // scan box and open run as the bench sees them
   logic [BOX_W-1:0]   scan_left = '0;
   logic [BOX_W-1:0]   scan_top = '0;
   logic [BOX_W-1:0]   scan_right = BOX_RIGHT_RST;
   logic [BOX_W-1:0]   scan_bottom = BOX_BOTTOM_RST;
   logic               run_live = 1'b0;
   logic [COORD_W-1:0] live_row = '0;
   logic [COORD_W-1:0] live_first = '0;
   logic [COORD_W-1:0] live_last = '0;

   run_word_type runs_due[$];

   int mismatches = 0;
   int pixels_sent = 0;
   int runs_checked = 0;
   int box_settings = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold = 0;
   int quiet_cycles = 0;

   binary_run_length_encoder_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_column (req_pixel_column),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_run_row      (rsp_run_row),
      .rsp_run_begin    (rsp_run_begin),
      .rsp_run_end      (rsp_run_end),
      .rsp_run_valid    (rsp_run_valid),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_item_last    (rsp_item_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic run_word_type make_run(input logic [COORD_W-1:0] row, first, last,
                                             input logic valid, done);
      run_word_type w;
      w.row       = row;
      w.first     = first;
      w.last      = last;
      w.valid     = valid;
      w.done      = done;
      w.item_last = 1'b0;
      return w;
   endfunction

   // encode one accepted pixel and queue the runs it releases
   function automatic void encode_pixel(input logic [VALUE_W-1:0] value,
                                        input logic [COORD_W-1:0] row, col,
                                        input logic fend);
      run_word_type out[$];
      logic in_box;
      in_box = int'(row) < ImageDimDef && int'(col) < ImageDimDef &&
               col >= scan_left && col < scan_right &&
               row >= scan_top && row < scan_bottom;
      if (in_box) begin
         if (value != '0) begin
            if (run_live && row == live_row &&
                {1'b0, col} == {1'b0, live_last} + 13'd1) begin
               live_last = col;
            end else begin
               if (run_live)
                  out.insert(out.size(),
                             make_run(live_row, live_first, live_last, 1'b1, 1'b0));
               run_live   = 1'b1;
               live_row   = row;
               live_first = col;
               live_last  = col;
            end
         end else if (run_live) begin
            out.insert(out.size(), make_run(live_row, live_first, live_last, 1'b1, 1'b0));
            run_live = 1'b0;
         end
      end
      if (fend) begin
         if (run_live) begin
            out.insert(out.size(), make_run(live_row, live_first, live_last, 1'b1, 1'b1));
            run_live = 1'b0;
         end else begin
            out.insert(out.size(), make_run('0, '0, '0, 1'b0, 1'b1));
         end
      end
      if (out.size() != 0)
         out[out.size()-1].item_last = 1'b1;
      foreach (out[i])
         runs_due.insert(runs_due.size(), out[i]);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic drive_pixel(input logic [VALUE_W-1:0] value,
                              input logic [COORD_W-1:0] row, col,
                              input logic fend);
      if (req_gap_pct > 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel_value  <= value;
      req_pixel_row    <= row;
      req_pixel_column <= col;
      req_frame_end    <= fend;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      encode_pixel(value, row, col, fend);
      pixels_sent++;
   endtask

   // drain every request and the pipeline behind it
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (runs_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [BOX_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      case (index)
         CSR_BOX_LEFT:   scan_left = data;
         CSR_BOX_TOP:    scan_top = data;
         CSR_BOX_RIGHT:  scan_right = data;
         CSR_BOX_BOTTOM: scan_bottom = data;
         default: ;
      endcase
   endtask

   task automatic set_box(input int left, top, right, bottom);
      settle_idle();
      write_csr(CSR_BOX_LEFT, BOX_W'(left));
      write_csr(CSR_BOX_TOP, BOX_W'(top));
      write_csr(CSR_BOX_RIGHT, BOX_W'(right));
      write_csr(CSR_BOX_BOTTOM, BOX_W'(bottom));
      csr_write <= 1'b0;
      @(posedge clock);
      box_settings++;
   endtask

   // raster scan of a small frame with clustered foreground
   task automatic scan_frame(input int row0, col0, rows, cols);
      int r;
      int c;
      logic fg;
      logic [VALUE_W-1:0] v;
      fg = 1'($urandom_range(0, 1));
      for (r = row0; r < row0 + rows; r++) begin
         for (c = col0; c < col0 + cols; c++) begin
            if ($urandom_range(0, 99) < 30)
               fg = !fg;
            v = fg ? VALUE_W'($urandom_range(1, 255)) : '0;
            if ($urandom_range(0, 99) < 4)
               v = VALUE_W'($urandom);
            drive_pixel(v, COORD_W'(r), COORD_W'(c), r == row0 + rows - 1 && c == col0 + cols - 1);
         end
      end
   endtask

   task automatic drive_noise(input int base_row, base_col);
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      repeat ($urandom_range(1, 5)) begin
         if ($urandom_range(0, 1)) begin
            row = COORD_W'($urandom);
            col = COORD_W'($urandom);
         end else begin
            row = COORD_W'(base_row + $urandom_range(0, 4));
            col = COORD_W'(base_col + $urandom_range(0, 20));
         end
         drive_pixel(VALUE_W'($urandom_range(0, 2) == 0 ? 0 : $urandom), row, col,
                     $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic test_directed_runs();
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      drive_pixel(8'd0, 12'd0, 12'd0, 1'b1);
      drive_pixel(8'd255, 12'd0, 12'd0, 1'b0);
      drive_pixel(8'd1, 12'd0, 12'd1, 1'b0);
      drive_pixel(8'd0, 12'd0, 12'd2, 1'b0);
      drive_pixel(8'd0, 12'd0, 12'd3, 1'b0);
      // run reaching the last column, then column zero of the same row
      drive_pixel(8'd128, 12'd4095, 12'd4094, 1'b0);
      drive_pixel(8'd7, 12'd4095, 12'd4095, 1'b0);
      drive_pixel(8'd3, 12'd4095, 12'd0, 1'b0);
      drive_pixel(8'd200, 12'd10, 12'd20, 1'b1);
      drive_pixel(8'd1, 12'd5, 12'd10, 1'b0);
      drive_pixel(8'd1, 12'd5, 12'd12, 1'b0);
      drive_pixel(8'd1, 12'd6, 12'd13, 1'b0);
      drive_pixel(8'd0, 12'd6, 12'd14, 1'b1);
      drive_pixel(8'd9, 12'd7, 12'd7, 1'b1);
      drive_pixel(8'd1, 12'd8, 12'd0, 1'b0);
      drive_pixel(8'd1, 12'd8, 12'd1, 1'b1);
   endtask

   task automatic test_box_edges();
      set_box(100, 50, 200, 60);
      drive_pixel(8'd1, 12'd50, 12'd99, 1'b0);
      drive_pixel(8'd1, 12'd50, 12'd100, 1'b0);
      drive_pixel(8'd0, 12'd49, 12'd101, 1'b0);
      drive_pixel(8'd1, 12'd50, 12'd101, 1'b0);
      drive_pixel(8'd0, 12'd60, 12'd102, 1'b1);
      drive_pixel(8'd1, 12'd59, 12'd199, 1'b0);
      drive_pixel(8'd1, 12'd59, 12'd200, 1'b1);
      // a write to an unused index must leave the box alone
      settle_idle();
      write_csr(CSR_SPARE, '0);
      csr_write <= 1'b0;
      @(posedge clock);
      drive_pixel(8'd1, 12'd55, 12'd150, 1'b1);
      set_box(300, 300, 300, 300);
      drive_pixel(8'd255, 12'd300, 12'd300, 1'b1);
      set_box(4096, 0, 0, 4096);
      drive_pixel(8'd1, 12'd0, 12'd4095, 1'b1);
   endtask

   task automatic test_random_frames(input int target);
      int base_row;
      int base_col;
      int phase_end;
      int left;
      int top;
      int right;
      int bottom;
      while (pixels_sent < target) begin
         req_gap_pct   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 30);
         rsp_stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 30);
         case ($urandom_range(0, 3))
            0: begin
               base_row = 0;
               base_col = 0;
            end
            1: begin
               base_row = 4092;
               base_col = 4076;
            end
            default: begin
               base_row = $urandom_range(0, 4092);
               base_col = $urandom_range(0, 4076);
            end
         endcase
         if ($urandom_range(0, 3) == 0) begin
            set_box(0, 0, 4096, 4096);
         end else begin
            left   = base_col + $urandom_range(0, 5);
            right  = base_col + $urandom_range(2, 24);
            top    = base_row + $urandom_range(0, 1);
            bottom = base_row + $urandom_range(1, 5);
            set_box(left, top, right > 4096 ? 4096 : right, bottom > 4096 ? 4096 : bottom);
         end
         phase_end = pixels_sent + $urandom_range(100, 180);
         while (pixels_sent < phase_end) begin
            if ($urandom_range(0, 99) < 85)
               scan_frame(base_row, base_col, $urandom_range(1, 4), $urandom_range(3, 20));
            else
               drive_noise(base_row, base_col);
         end
      end
   endtask

   task automatic test_full_rate();
      set_box(0, 0, 4096, 4096);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      while (pixels_sent < PIXEL_TARGET)
         scan_frame($urandom_range(0, 4092), $urandom_range(0, 4076),
                    $urandom_range(1, 4), $urandom_range(3, 20));
   endtask

   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_runs
      run_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (runs_due.size() == 0) begin
            report_mismatch("run with nothing queued, run_row", rsp_run_row, -1);
         end else begin
            want = runs_due.pop_front();
            if (rsp_run_row !== want.row)
               report_mismatch("run_row", rsp_run_row, want.row);
            if (rsp_run_begin !== want.first)
               report_mismatch("run_begin", rsp_run_begin, want.first);
            if (rsp_run_end !== want.last)
               report_mismatch("run_end", rsp_run_end, want.last);
            if (rsp_run_valid !== want.valid)
               report_mismatch("run_valid", rsp_run_valid, want.valid);
            if (rsp_frame_done !== want.done)
               report_mismatch("frame_done", rsp_frame_done, want.done);
            if (rsp_item_last !== want.item_last)
               report_mismatch("item_last", rsp_item_last, want.item_last);
         end
         runs_checked++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_runs();
      test_box_edges();
      test_random_frames(PIXEL_TARGET - FULL_RATE_SHARE);
      test_full_rate();
      settle_idle();
      repeat (10) @(posedge clock);
      $display("Encoded %0d pixels under %0d scan boxes; %0d runs and markers compared.",
               pixels_sent, box_settings, runs_checked);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/brle_pkg.sv
design/brle_front.sv
design/brle_queue.sv
design/brle_back.sv
design/binary_run_length_encoder_unit.sv
design/brle_checker.sv
bench/tb_binary_run_length_encoder_unit.sv
